/* hw/rtl/lgs_pkg.sv */
package lgs_pkg;

	// table sizes
	localparam int MAX_TOPICS = 64;
	localparam int MAX_WORDS  = 16384;
	localparam int MAX_DOCS   = 4096;
	localparam int MAX_TOKENS = 1048576;

	// count and arithmetic widths
	localparam int CNT_W  = 21;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam int CFG_W  = 24;
	localparam int ALPHA_W = 24;
	localparam int BETA_W = 24;
	localparam int KCFG_W = 7;
	localparam int VOCAB_W = 15;
	localparam int A_W    = 38;
	localparam int HALF_W = 19;
	localparam int PP_W   = A_W + HALF_W;
	localparam int PROD_W = 2 * A_W;
	localparam int BV_W   = BETA_W + VOCAB_W;
	localparam int DEN_W  = 40;
	localparam int WGT_W  = 48;
	localparam logic [WGT_W-1:0] WGT_MAX = {WGT_W{1'b1}};
	localparam int RND_W  = 32;
	localparam int DIV_CNT_W = 7;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_ALPHA  = 2'd0,
		CFG_BETA   = 2'd1,
		CFG_TOPICS = 2'd2,
		CFG_VOCAB  = 2'd3
	} cfg_idx_t;

	// controller states
	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE,
		ST_BASE, ST_OLD_RD, ST_OLD_LAT, ST_REM_RD, ST_REM_WR,
		ST_W_RD, ST_W_LAT, ST_W_MUL0, ST_W_MUL1, ST_W_DIV, ST_W_DIV_W, ST_W_ACC,
		ST_TH0, ST_TH1, ST_S_RD, ST_S_LAT, ST_UPD_RD, ST_UPD_WR, ST_DONE
	} state_t;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE, OP_CLEAR, OP_LOAD,
		OP_BASE, OP_OLD_LAT, OP_REM_RD, OP_REM_WR,
		OP_W_RD, OP_W_LAT, OP_MUL0, OP_MUL1, OP_DIV_W, OP_ST_WGT, OP_ACC,
		OP_TH0, OP_TH1, OP_S_LAT, OP_UPD_RD, OP_UPD_WR, OP_EMIT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic has_old;
		logic t_last;
		logic hit;
		logic out_free;
	} status_t;

endpackage

/* hw/rtl/lda_collapsed_gibbs_token_sampler.sv */
// Each token reads its previous topic, removes it from the counts when there is one, weighs
// the K topics in use, scans them in the draw and adds the drawn topic back. The weights pass
// through the bit-serial weight divider, one topic at a time. Only one token is processed at
// a time; the next token is accepted while the result word waits. Reset (arst_n low):
// registers go to their defaults, then a clearing pass over max(MAX_TOKENS,
// MAX_WORDS*MAX_TOPICS, MAX_DOCS*MAX_TOPICS) addresses runs before input is accepted.
module lda_collapsed_gibbs_token_sampler
	import lgs_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_en,
	input  logic [1:0]                    cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [19:0]                   token_index,
	input  logic [13:0]                   word_id,
	input  logic [11:0]                   doc_id,
	input  logic [RND_W-1:0]              random_fraction,
	input  logic                          sweep_start,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [$clog2(MAX_TOPICS)-1:0] drawn_topic,
	output logic                          topic_changed,
	output logic [CNT_W-1:0]              changes_in_sweep
);

	cmd_t    cmd;
	status_t status;

	// sequencer
	lgs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	// count tables, weight arithmetic and result word
	lgs_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_en          (cfg_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.token_index     (token_index),
		.word_id         (word_id),
		.doc_id          (doc_id),
		.random_fraction (random_fraction),
		.sweep_start     (sweep_start),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.drawn_topic     (drawn_topic),
		.topic_changed   (topic_changed),
		.changes_in_sweep(changes_in_sweep)
	);

endmodule

/* hw/rtl/lgs_ram.sv */
module lgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/lgs_div.sv */
module lgs_div
	import lgs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] num,
	input  logic [DEN_W-1:0]  den,
	output logic              done,
	output logic [PROD_W-1:0] quo
);

	logic [PROD_W-1:0]    num_q;
	logic [PROD_W-1:0]    quo_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DEN_W:0]       trial;
	logic                 fits;

	// restoring step: one quotient bit per cycle
	assign trial = {rem_q, num_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[PROD_W-2:0], 1'b0};
			quo_q <= {quo_q[PROD_W-2:0], fits};
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* hw/rtl/lgs_ctrl.sv */
module lgs_ctrl
	import lgs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath command
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (status.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_BASE;
				end
			end
			ST_BASE: begin
				cmd.op  = OP_BASE;
				state_d = ST_OLD_RD;
			end
			ST_OLD_RD: begin
				state_d = ST_OLD_LAT;
			end
			ST_OLD_LAT: begin
				cmd.op  = OP_OLD_LAT;
				state_d = status.has_old ? ST_REM_RD : ST_W_RD;
			end
			ST_REM_RD: begin
				cmd.op  = OP_REM_RD;
				state_d = ST_REM_WR;
			end
			ST_REM_WR: begin
				cmd.op  = OP_REM_WR;
				state_d = ST_W_RD;
			end
			ST_W_RD: begin
				cmd.op  = OP_W_RD;
				state_d = ST_W_LAT;
			end
			ST_W_LAT: begin
				cmd.op  = OP_W_LAT;
				state_d = ST_W_MUL0;
			end
			ST_W_MUL0: begin
				cmd.op  = OP_MUL0;
				state_d = ST_W_MUL1;
			end
			ST_W_MUL1: begin
				cmd.op  = OP_MUL1;
				state_d = ST_W_DIV;
			end
			ST_W_DIV: begin
				cmd.op  = OP_DIV_W;
				state_d = ST_W_DIV_W;
			end
			ST_W_DIV_W: begin
				cmd.op = OP_ST_WGT;
				if (status.div_done) state_d = ST_W_ACC;
			end
			ST_W_ACC: begin
				cmd.op  = OP_ACC;
				state_d = status.t_last ? ST_TH0 : ST_W_RD;
			end
			ST_TH0: begin
				cmd.op  = OP_TH0;
				state_d = ST_TH1;
			end
			ST_TH1: begin
				cmd.op  = OP_TH1;
				state_d = ST_S_RD;
			end
			ST_S_RD: begin
				state_d = ST_S_LAT;
			end
			ST_S_LAT: begin
				cmd.op  = OP_S_LAT;
				state_d = (status.hit || status.t_last) ? ST_UPD_RD : ST_S_RD;
			end
			ST_UPD_RD: begin
				cmd.op  = OP_UPD_RD;
				state_d = ST_UPD_WR;
			end
			ST_UPD_WR: begin
				cmd.op  = OP_UPD_WR;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/lgs_datapath.sv */
module lgs_datapath
	import lgs_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output status_t                       status,
	input  logic                          cfg_en,
	input  logic [1:0]                    cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic [19:0]                   token_index,
	input  logic [13:0]                   word_id,
	input  logic [11:0]                   doc_id,
	input  logic [RND_W-1:0]              random_fraction,
	input  logic                          sweep_start,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [$clog2(MAX_TOPICS)-1:0] drawn_topic,
	output logic                          topic_changed,
	output logic [CNT_W-1:0]              changes_in_sweep
);

	localparam int TW      = $clog2(MAX_TOPICS);
	localparam int KW      = $clog2(MAX_TOPICS + 1);
	localparam int SW      = TW + 1;
	localparam int TOK_AW  = $clog2(MAX_TOKENS);
	localparam int DOC_D   = MAX_DOCS * MAX_TOPICS;
	localparam int DOC_AW  = $clog2(DOC_D);
	localparam int WRD_D   = MAX_WORDS * MAX_TOPICS;
	localparam int WRD_AW  = $clog2(WRD_D);
	localparam int CLR_A   = (DOC_D > WRD_D) ? DOC_D : WRD_D;
	localparam int CLR_LEN = (CLR_A > MAX_TOKENS) ? CLR_A : MAX_TOKENS;
	localparam int CLR_W   = $clog2(CLR_LEN);
	localparam int TOT_W   = WGT_W + TW;
	localparam logic [SW-1:0] NO_TOPIC = {SW{1'b1}};

	op_t op;
	assign op = cmd.op;

	// configuration registers
	logic [ALPHA_W-1:0] alpha_q;
	logic [BETA_W-1:0]  beta_q;
	logic [KCFG_W-1:0]  kcfg_q;
	logic [VOCAB_W-1:0] vocab_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_W'(65536);
			beta_q  <= BETA_W'(6554);
			kcfg_q  <= KCFG_W'(50);
			vocab_q <= VOCAB_W'(16384);
		end else if (cfg_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ALPHA:  alpha_q <= cfg_data;
				CFG_BETA:   beta_q  <= cfg_data;
				CFG_TOPICS: kcfg_q  <= KCFG_W'(cfg_data);
				CFG_VOCAB:  vocab_q <= VOCAB_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// token word registers
	logic [19:0]        tok_q;
	logic [13:0]        wid_q;
	logic [11:0]        did_q;
	logic [RND_W-1:0]   u_q;
	logic [DOC_AW-1:0]  doc_base_q;
	logic [WRD_AW-1:0]  wrd_base_q;
	logic [KW-1:0]      k_q;
	logic [BV_W-1:0]    bv_q;
	logic [TW-1:0]      t_q;
	logic [SW-1:0]      old_q;
	logic               has_old_q;
	logic [TW-1:0]      newt_q;
	logic [A_W-1:0]     a_q;
	logic [A_W-1:0]     b_q;
	logic [DEN_W-1:0]   d_q;
	logic [PROD_W-1:0]  prod_q;
	logic [WGT_W-1:0]   wgt_q;
	logic [TOT_W-1:0]   total_q;
	logic [TOT_W-1:0]   thr_q;
	logic [TOT_W-1:0]   cum_q;
	logic [CLR_W-1:0]   clr_addr_q;
	logic [CNT_W-1:0]   chg_q;

	// weight divider
	logic              div_start;
	logic              div_done;
	logic [PROD_W-1:0] div_quo;

	assign div_start = (op == OP_DIV_W);

	lgs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (prod_q),
		.den   (d_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// topic that the count tables address
	logic [TW-1:0] tsel;
	always_comb begin
		case (op)
			OP_REM_RD, OP_REM_WR: tsel = old_q[TW-1:0];
			OP_UPD_RD, OP_UPD_WR: tsel = newt_q;
			default:              tsel = t_q;
		endcase
	end

	// memories
	logic              tok_we;
	logic [TOK_AW-1:0] tok_waddr;
	logic [SW-1:0]     tok_wdata;
	logic [SW-1:0]     tok_rd;
	logic              doc_we;
	logic [DOC_AW-1:0] doc_waddr;
	logic [DOC_AW-1:0] doc_raddr;
	logic [CNT_W-1:0]  doc_wdata;
	logic [CNT_W-1:0]  doc_rd;
	logic              wrd_we;
	logic [WRD_AW-1:0] wrd_waddr;
	logic [WRD_AW-1:0] wrd_raddr;
	logic [CNT_W-1:0]  wrd_wdata;
	logic [CNT_W-1:0]  wrd_rd;
	logic              tot_we;
	logic [TW-1:0]     tot_waddr;
	logic [CNT_W-1:0]  tot_wdata;
	logic [CNT_W-1:0]  tot_rd;
	logic              wgt_we;
	logic [WGT_W-1:0]  wgt_rd;
	logic              clearing;

	assign clearing  = (op == OP_CLEAR);
	assign doc_raddr = doc_base_q + DOC_AW'(tsel);
	assign wrd_raddr = wrd_base_q + WRD_AW'(tsel);

	function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] c);
		dec_sat = (c == '0) ? c : c - 1'b1;
	endfunction

	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
		inc_sat = (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

	// write port selection: clear sweep, removal, add-back
	always_comb begin
		tok_we    = 1'b0;
		tok_waddr = TOK_AW'(tok_q);
		tok_wdata = {1'b0, newt_q};
		doc_we    = 1'b0;
		doc_waddr = doc_raddr;
		doc_wdata = inc_sat(doc_rd);
		wrd_we    = 1'b0;
		wrd_waddr = wrd_raddr;
		wrd_wdata = inc_sat(wrd_rd);
		tot_we    = 1'b0;
		tot_waddr = tsel;
		tot_wdata = inc_sat(tot_rd);
		if (clearing) begin
			tok_we    = 32'(clr_addr_q) < MAX_TOKENS;
			tok_waddr = TOK_AW'(clr_addr_q);
			tok_wdata = NO_TOPIC;
			doc_we    = 32'(clr_addr_q) < DOC_D;
			doc_waddr = DOC_AW'(clr_addr_q);
			doc_wdata = '0;
			wrd_we    = 32'(clr_addr_q) < WRD_D;
			wrd_waddr = WRD_AW'(clr_addr_q);
			wrd_wdata = '0;
			tot_we    = 32'(clr_addr_q) < MAX_TOPICS;
			tot_waddr = TW'(clr_addr_q);
			tot_wdata = '0;
		end else if (op == OP_REM_WR) begin
			doc_we    = 1'b1;
			doc_wdata = dec_sat(doc_rd);
			wrd_we    = 1'b1;
			wrd_wdata = dec_sat(wrd_rd);
			tot_we    = 1'b1;
			tot_wdata = dec_sat(tot_rd);
		end else if (op == OP_UPD_WR) begin
			tok_we = 1'b1;
			doc_we = 1'b1;
			wrd_we = 1'b1;
			tot_we = 1'b1;
		end
	end

	assign wgt_we = (op == OP_ACC);

	lgs_ram #(.WIDTH(SW), .DEPTH(MAX_TOKENS)) u_tok_mem (
		.clk(clk), .we(tok_we), .waddr(tok_waddr), .wdata(tok_wdata),
		.raddr(TOK_AW'(tok_q)), .rdata(tok_rd)
	);

	lgs_ram #(.WIDTH(CNT_W), .DEPTH(DOC_D)) u_doc_mem (
		.clk(clk), .we(doc_we), .waddr(doc_waddr), .wdata(doc_wdata),
		.raddr(doc_raddr), .rdata(doc_rd)
	);

	lgs_ram #(.WIDTH(CNT_W), .DEPTH(WRD_D)) u_wrd_mem (
		.clk(clk), .we(wrd_we), .waddr(wrd_waddr), .wdata(wrd_wdata),
		.raddr(wrd_raddr), .rdata(wrd_rd)
	);

	lgs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_TOPICS)) u_tot_mem (
		.clk(clk), .we(tot_we), .waddr(tot_waddr), .wdata(tot_wdata),
		.raddr(tsel), .rdata(tot_rd)
	);

	lgs_ram #(.WIDTH(WGT_W), .DEPTH(MAX_TOPICS)) u_wgt_mem (
		.clk(clk), .we(wgt_we), .waddr(t_q), .wdata(wgt_q),
		.raddr(t_q), .rdata(wgt_rd)
	);

	// shared multipliers
	logic [HALF_W-1:0]  b_half;
	logic [PP_W-1:0]    pp;
	logic [RND_W-1:0]   u_opd;
	logic [2*RND_W-1:0] um;
	logic [TOT_W-1:0]   cum_next;
	logic [31:0]        k_raw;
	logic [DEN_W-1:0]   d_next;

	assign b_half   = (op == OP_MUL1) ? b_q[A_W-1:HALF_W] : b_q[HALF_W-1:0];
	assign pp       = a_q * b_half;
	assign u_opd    = (op == OP_TH1) ? RND_W'(total_q[TOT_W-1:RND_W]) : total_q[RND_W-1:0];
	assign um       = u_q * u_opd;
	assign cum_next = cum_q + TOT_W'(wgt_rd);
	assign k_raw    = 32'(kcfg_q);
	assign d_next   = DEN_W'(bv_q) + DEN_W'({tot_rd, 16'b0});

	// status back to the controller
	assign status.clr_last = (32'(clr_addr_q) == CLR_LEN - 1);
	assign status.div_done = div_done;
	assign status.has_old  = (tok_rd != NO_TOPIC);
	assign status.t_last   = (KW'(t_q) + KW'(1) == k_q);
	assign status.hit      = (cum_next > thr_q);
	assign status.out_free = !out_valid || !out_stall;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q    <= '0;
			chg_q         <= '0;
			out_valid     <= 1'b0;
			drawn_topic   <= '0;
			topic_changed <= 1'b0;
			changes_in_sweep <= '0;
		end else begin
			if (clearing) clr_addr_q <= clr_addr_q + 1'b1;
			if (op == OP_LOAD && sweep_start) chg_q <= '0;
			if (op == OP_UPD_WR && (!has_old_q || old_q != {1'b0, newt_q})) begin
				chg_q <= inc_sat(chg_q);
			end
			if (op == OP_EMIT) begin
				out_valid        <= 1'b1;
				drawn_topic      <= newt_q;
				topic_changed    <= !has_old_q || old_q != {1'b0, newt_q};
				changes_in_sweep <= chg_q;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				tok_q <= token_index;
				wid_q <= word_id;
				did_q <= doc_id;
				u_q   <= random_fraction;
			end
			OP_BASE: begin
				doc_base_q <= DOC_AW'(32'(did_q) * 32'(MAX_TOPICS));
				wrd_base_q <= WRD_AW'(32'(wid_q) * 32'(MAX_TOPICS));
				if (k_raw == 0) k_q <= KW'(1);
				else if (k_raw > MAX_TOPICS) k_q <= KW'(MAX_TOPICS);
				else k_q <= KW'(k_raw);
				bv_q    <= beta_q * vocab_q;
				t_q     <= '0;
				total_q <= '0;
				has_old_q <= 1'b0;
				old_q   <= NO_TOPIC;
			end
			OP_OLD_LAT: begin
				old_q     <= tok_rd;
				has_old_q <= (tok_rd != NO_TOPIC);
			end
			OP_W_LAT: begin
				a_q <= A_W'(alpha_q) + A_W'({doc_rd, 16'b0});
				b_q <= A_W'(beta_q) + A_W'({wrd_rd, 16'b0});
				d_q <= (d_next == '0) ? DEN_W'(1) : d_next;
			end
			OP_MUL0: prod_q <= PROD_W'(pp);
			OP_MUL1: prod_q <= prod_q + PROD_W'({pp, {HALF_W{1'b0}}});
			OP_ST_WGT: begin
				if (div_done) begin
					wgt_q <= (div_quo > PROD_W'(WGT_MAX)) ? WGT_MAX : div_quo[WGT_W-1:0];
				end
			end
			OP_ACC: begin
				total_q <= total_q + TOT_W'(wgt_q);
				if (!status.t_last) t_q <= t_q + 1'b1;
			end
			OP_TH0: thr_q <= TOT_W'(um >> RND_W);
			OP_TH1: begin
				thr_q <= thr_q + TOT_W'(um);
				t_q   <= '0;
				cum_q <= '0;
			end
			OP_S_LAT: begin
				cum_q <= cum_next;
				if (status.hit || status.t_last) newt_q <= t_q;
				else t_q <= t_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule

/* test/tb_lda_collapsed_gibbs_token_sampler.sv */
module tb_lda_collapsed_gibbs_token_sampler;
	import lgs_pkg::*;

	localparam int NTOPIC = 64;
	localparam int NWORD = 16384;
	localparam int NDOC = 4096;
	localparam int NTOK = 1048576;
	localparam logic [6:0] NO_TOPIC = 7'd127;
	// the limit sits well above the reset clearing pass over all token addresses
	localparam int IDLE_LIMIT = 3000000;

	typedef struct {
		logic [5:0]       topic;
		logic             changed;
		logic [CNT_W-1:0] changes;
	} draw_t;

	// topic sampler predictor plus queue of expected draws
	class draw_scoreboard;
		logic [6:0]       tok_topic[NTOK];
		logic [CNT_W-1:0] doc_cnt[NDOC*NTOPIC];
		logic [CNT_W-1:0] word_cnt[NWORD*NTOPIC];
		logic [CNT_W-1:0] tot_cnt[NTOPIC];
		logic [CNT_W-1:0] change_cnt;
		logic [23:0]      alpha, beta;
		logic [6:0]       k_cfg;
		logic [14:0]      vocab;
		draw_t            pending_draws[$];
		int               errors;

		function new();
			foreach (tok_topic[i]) tok_topic[i] = NO_TOPIC;
			foreach (doc_cnt[i]) doc_cnt[i] = '0;
			foreach (word_cnt[i]) word_cnt[i] = '0;
			foreach (tot_cnt[i]) tot_cnt[i] = '0;
			change_cnt = '0;
			alpha = 24'd65536;
			beta = 24'd6554;
			k_cfg = 7'd50;
			vocab = 15'd16384;
			errors = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_ALPHA:  alpha = val[23:0];
				CFG_BETA:   beta = val[23:0];
				CFG_TOPICS: k_cfg = val[6:0];
				CFG_VOCAB:  vocab = val[14:0];
				default: ;
			endcase
		endfunction

		// accepted token: remove old topic, weigh topics, draw, add back
		function void note_token(logic [19:0] tok, logic [13:0] w, logic [11:0] d,
				logic [31:0] u, logic sw);
			int k, db, wb, t;
			logic [6:0]  old;
			logic        has_old, chg;
			logic [5:0]  pick;
			logic [37:0] a, b;
			logic [39:0] den;
			logic [75:0] q;
			logic [47:0] wgt[NTOPIC];
			logic [63:0] total, cum, thr;
			logic [95:0] ut;
			draw_t       e;
			if (sw) change_cnt = '0;
			k = k_cfg;
			if (k < 1) k = 1;
			if (k > NTOPIC) k = NTOPIC;
			db = d * NTOPIC;
			wb = w * NTOPIC;
			old = tok_topic[tok];
			has_old = (old != NO_TOPIC) && (old < NTOPIC);
			if (has_old) begin
				if (doc_cnt[db+old] != 0) doc_cnt[db+old]--;
				if (word_cnt[wb+old] != 0) word_cnt[wb+old]--;
				if (tot_cnt[old] != 0) tot_cnt[old]--;
			end
			total = '0;
			for (t = 0; t < k; t++) begin
				a = {14'b0, alpha} + {1'b0, doc_cnt[db+t], 16'b0};
				b = {14'b0, beta} + {1'b0, word_cnt[wb+t], 16'b0};
				den = 40'(beta) * 40'(vocab) + {3'b0, tot_cnt[t], 16'b0};
				if (den == 0) den = 1;
				q = (76'(a) * 76'(b)) / 76'(den);
				wgt[t] = (q > 76'(WGT_MAX)) ? WGT_MAX : q[47:0];
				total += 64'(wgt[t]);
			end
			ut = 96'(u) * 96'(total);
			thr = ut[95:32];
			pick = 6'(k - 1);
			cum = '0;
			for (t = 0; t < k; t++) begin
				cum += 64'(wgt[t]);
				if (cum > thr) begin
					pick = 6'(t);
					break;
				end
			end
			tok_topic[tok] = {1'b0, pick};
			chg = !has_old || (old != {1'b0, pick});
			if (chg && change_cnt != CNT_MAX) change_cnt++;
			if (doc_cnt[db+pick] != CNT_MAX) doc_cnt[db+pick]++;
			if (word_cnt[wb+pick] != CNT_MAX) word_cnt[wb+pick]++;
			if (tot_cnt[pick] != CNT_MAX) tot_cnt[pick]++;
			e.topic = pick;
			e.changed = chg;
			e.changes = change_cnt;
			pending_draws.insert(pending_draws.size(), e);
		endfunction

		function void check_draw(logic [5:0] topic, logic changed, logic [CNT_W-1:0] changes);
			draw_t e;
			if (pending_draws.size() == 0) begin
				$display("%0t: unexpected result word topic=%0d changed=%0d count=%0d",
					$time, topic, changed, changes);
				errors++;
				return;
			end
			e = pending_draws.pop_front();
			if (topic !== e.topic) begin
				$display("%0t: drawn_topic expected %0d actual %0d", $time, e.topic, topic);
				errors++;
			end
			if (changed !== e.changed) begin
				$display("%0t: topic_changed expected %0d actual %0d", $time, e.changed,
					changed);
				errors++;
			end
			if (changes !== e.changes) begin
				$display("%0t: changes_in_sweep expected %0d actual %0d", $time, e.changes,
					changes);
				errors++;
			end
		endfunction
	endclass

	logic             clk, arst_n;
	logic             cfg_en;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid, in_stall;
	logic [19:0]      token_index;
	logic [13:0]      word_id;
	logic [11:0]      doc_id;
	logic [RND_W-1:0] random_fraction;
	logic             sweep_start;
	logic             out_valid, out_stall;
	logic [5:0]       drawn_topic;
	logic             topic_changed;
	logic [CNT_W-1:0] changes_in_sweep;

	draw_scoreboard sb = new();
	int sent = 0;
	int idle_cycles = 0;
	int send_idle_pct = 33;
	int recv_idle_pct = 68;

	lda_collapsed_gibbs_token_sampler u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.token_index(token_index), .word_id(word_id), .doc_id(doc_id),
		.random_fraction(random_fraction), .sweep_start(sweep_start),
		.out_valid(out_valid), .out_stall(out_stall),
		.drawn_topic(drawn_topic), .topic_changed(topic_changed),
		.changes_in_sweep(changes_in_sweep)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// result side: random stall and checking
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_draw(drawn_topic, topic_changed, changes_in_sweep);
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// idle pattern follows progress through the item count
	task automatic update_idling();
		if (sent < 333) begin
			send_idle_pct = 33; recv_idle_pct = 68;
		end else if (sent < 666) begin
			send_idle_pct = 68; recv_idle_pct = 33;
		end else begin
			send_idle_pct = 0; recv_idle_pct = 0;
		end
	endtask

	task automatic send_token(logic [19:0] tok, logic [13:0] w, logic [11:0] d,
			logic [31:0] u, logic sw);
		update_idling();
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		token_index <= tok;
		word_id <= w;
		doc_id <= d;
		random_fraction <= u;
		sweep_start <= sw;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_token(tok, w, d, u, sw);
		sent++;
	endtask

	// config writes only once the block has drained
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_draws.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_en <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic set_config(logic [23:0] a, logic [23:0] b, logic [6:0] k, logic [14:0] v);
		drain();
		write_reg(CFG_ALPHA, a);
		write_reg(CFG_BETA, b);
		write_reg(CFG_TOPICS, {17'b0, k});
		write_reg(CFG_VOCAB, {9'b0, v});
	endtask

	// mostly a small corpus so counts build up; sometimes full-range noise
	task automatic random_tokens(int n);
		logic [19:0] tok;
		logic [13:0] w;
		logic [11:0] d;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 8) begin
				tok = 20'($urandom_range(47));
				w = 14'($urandom_range(7));
				d = 12'($urandom_range(3));
			end else begin
				tok = 20'($urandom);
				w = 14'($urandom);
				d = 12'($urandom);
			end
			send_token(tok, w, d, $urandom, $urandom_range(19) == 0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_en = 1'b0;
		cfg_index = CFG_ALPHA;
		cfg_data = '0;
		in_valid = 1'b0;
		token_index = '0;
		word_id = '0;
		doc_id = '0;
		random_fraction = '0;
		sweep_start = 1'b0;
		out_stall = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults, field extremes, first use and reuse of tokens
		send_token(20'd0, 14'd0, 12'd0, 32'd0, 1'b1);
		send_token(20'hFFFFF, 14'h3FFF, 12'hFFF, 32'hFFFFFFFF, 1'b0);
		send_token(20'd0, 14'd0, 12'd0, 32'h80000000, 1'b0);
		send_token(20'd0, 14'h3FFF, 12'hFFF, 32'd0, 1'b0);
		send_token(20'hFFFFF, 14'd0, 12'd0, 32'hFFFFFFFF, 1'b1);
		send_token(20'h55555, 14'h2AAA, 12'hAAA, 32'h55555555, 1'b0);
		send_token(20'hAAAAA, 14'h1555, 12'h555, 32'hAAAAAAAA, 1'b0);

		// tiny priors: weights round to zero, fallback to last topic
		set_config(24'd1, 24'd1, 7'd4, 15'd16384);
		send_token(20'd1, 14'd1, 12'd1, 32'd0, 1'b1);
		send_token(20'd1, 14'd1, 12'd1, 32'hFFFFFFFF, 1'b0);
		send_token(20'd2, 14'd1, 12'd1, 32'd12345, 1'b0);
		random_tokens(40);

		// large priors, all topics, vocabulary of one
		set_config(24'hFFFFFF, 24'hFFFFFF, 7'd64, 15'd1);
		send_token(20'd0, 14'd5, 12'd2, 32'hFFFFFFFF, 1'b0);
		send_token(20'd3, 14'd5, 12'd2, 32'hC0000000, 1'b0);
		random_tokens(8);

		// one topic: previous topics beyond it still get removed
		set_config(24'd65536, 24'd6554, 7'd1, 15'd16384);
		random_tokens(40);

		set_config(24'd65536, 24'd6554, 7'd16, 15'd100);
		random_tokens(60);

		// random settings with few topics for the bulk
		while (sent < 1000) begin
			set_config(24'($urandom_range(24'hFFFFFF, 1)), 24'($urandom_range(24'hFFFFFF, 1)),
				7'($urandom_range(8, 2)), 15'($urandom_range(16384, 1)));
			random_tokens(120);
		end

		drain();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending_draws.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/lgs_pkg.sv
hw/rtl/lgs_ram.sv
hw/rtl/lgs_div.sv
hw/rtl/lgs_ctrl.sv
hw/rtl/lgs_datapath.sv
hw/rtl/lda_collapsed_gibbs_token_sampler.sv
test/tb_lda_collapsed_gibbs_token_sampler.sv
